FILE: hw/rtl/bbsf_pkg.sv
// Package for the bounded byte stream FIFO.
// Holds store geometry, operation codes and the controller/datapath interface structs.
// No dependencies.
`default_nettype none

package bbsf_pkg;

  // Store geometry; the depth is a power of two so that indexes wrap by truncation.
  localparam int DEPTH   = 1024;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int MAX_LEN = 64;
  localparam int LEN_W   = 7;
  localparam int OP_W    = 3;
  localparam int BYTE_W  = 8;
  localparam int TOT_W   = 32;

  // Capacity register value after reset.
  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(DEPTH);

  // Operation codes.
  localparam logic [OP_W-1:0] OP_WRITE = 3'd0;
  localparam logic [OP_W-1:0] OP_READ  = 3'd1;
  localparam logic [OP_W-1:0] OP_PEEK  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP   = 3'd3;
  localparam logic [OP_W-1:0] OP_END   = 3'd4;
  localparam logic [OP_W-1:0] OP_ERROR = 3'd5;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;         // capture a new request
    logic exec;         // apply the captured request to the state
    logic issue;        // read one byte from the store
    logic emit_status;  // present a single status result
  } bbsf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic stream;       // the request returns one or more stream bytes
    logic issue_last;   // the current store read is the final one
  } bbsf_sts_t;

endpackage

`default_nettype wire

FILE: hw/rtl/bounded_byte_stream_fifo.sv
// Bounded byte stream FIFO: 1024-byte store, capacity register, end and error flags.
// A write, pop, end, set-error, spare-opcode, empty read/peek or read in error gives one status
// result. A read or peek of n bytes streams n bytes, one byte per cycle through the store's
// registered read port. A new request is taken only once the previous one is finished.
// Results cannot be stalled. Synchronous active-low reset empties the FIFO, clears flags
// and counters and sets capacity to 1024; the store contents are not cleared.
`default_nettype none

module bounded_byte_stream_fifo (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [bbsf_pkg::OP_W-1:0]         in_op,
  input  wire logic [bbsf_pkg::BYTE_W-1:0]       in_write_byte,
  input  wire logic [bbsf_pkg::LEN_W-1:0]        in_length,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [bbsf_pkg::CNT_W-1:0]        cfg_capacity,
  output logic                                   out_strobe,
  output logic [bbsf_pkg::BYTE_W-1:0]            out_byte,
  output logic                                   out_byte_valid,
  output logic                                   out_last,
  output logic [bbsf_pkg::LEN_W-1:0]             out_moved,
  output logic [bbsf_pkg::CNT_W-1:0]             out_occupancy,
  output logic [bbsf_pkg::CNT_W-1:0]             out_free_space,
  output logic                                   out_ended,
  output logic                                   out_at_eof,
  output logic                                   out_error_flag,
  output logic [bbsf_pkg::TOT_W-1:0]             out_total_written,
  output logic [bbsf_pkg::TOT_W-1:0]             out_total_read
);

  bbsf_pkg::bbsf_cmd_t cmd;
  bbsf_pkg::bbsf_sts_t sts;

  // The capacity register accepts a write in any cycle out of reset.
  assign cfg_ready = 1'b1;

  // Request sequencing.
  bbsf_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // Store, state and result generation.
  bbsf_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_op             (in_op),
    .in_write_byte     (in_write_byte),
    .in_length         (in_length),
    .cfg_write         (cfg_valid && cfg_ready),
    .cfg_capacity      (cfg_capacity),
    .out_strobe        (out_strobe),
    .out_byte          (out_byte),
    .out_byte_valid    (out_byte_valid),
    .out_last          (out_last),
    .out_moved         (out_moved),
    .out_occupancy     (out_occupancy),
    .out_free_space    (out_free_space),
    .out_ended         (out_ended),
    .out_at_eof        (out_at_eof),
    .out_error_flag    (out_error_flag),
    .out_total_written (out_total_written),
    .out_total_read    (out_total_read)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/bbsf_ctrl.sv
// Controller for the bounded byte stream FIFO.
// Sequences capture, execution, byte streaming and status results; uses bbsf_pkg.
`default_nettype none

module bbsf_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire bbsf_pkg::bbsf_sts_t sts,
  output bbsf_pkg::bbsf_cmd_t    cmd
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_EXEC   = 5'b00010,
    ST_STREAM = 5'b00100,
    ST_DRAIN  = 5'b01000,
    ST_STATUS = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // Next state and command decode.
  always_comb begin
    state_nxt       = state_r;
    cmd             = '0;
    case (state_r)
      ST_IDLE: begin
        cmd.load = start;
        if (start) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = sts.stream ? ST_STREAM : ST_STATUS;
      end
      ST_STREAM: begin
        cmd.issue = 1'b1;
        if (sts.issue_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // The final byte leaves the store read register in this cycle.
        state_nxt = ST_IDLE;
      end
      ST_STATUS: begin
        cmd.emit_status = 1'b1;
        state_nxt       = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // A request is only captured while idle.
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (state_r == ST_IDLE))
    else $error("request captured while busy");

  // Execution always follows a capture in the next cycle.
  a_exec_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> cmd.exec)
    else $error("capture not followed by execution");

  // A status result never overlaps store reads.
  a_status_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.emit_status && cmd.issue))
    else $error("status result during streaming");

endmodule

`default_nettype wire

FILE: hw/rtl/bbsf_dp.sv
// Datapath for the bounded byte stream FIFO.
// Holds the byte store, pointers, flags, counters and result registers; uses bbsf_pkg.
`default_nettype none

module bbsf_dp (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire bbsf_pkg::bbsf_cmd_t               cmd,
  output bbsf_pkg::bbsf_sts_t                    sts,
  input  wire logic [bbsf_pkg::OP_W-1:0]         in_op,
  input  wire logic [bbsf_pkg::BYTE_W-1:0]       in_write_byte,
  input  wire logic [bbsf_pkg::LEN_W-1:0]        in_length,
  input  wire logic                              cfg_write,
  input  wire logic [bbsf_pkg::CNT_W-1:0]        cfg_capacity,
  output logic                                   out_strobe,
  output logic [bbsf_pkg::BYTE_W-1:0]            out_byte,
  output logic                                   out_byte_valid,
  output logic                                   out_last,
  output logic [bbsf_pkg::LEN_W-1:0]             out_moved,
  output logic [bbsf_pkg::CNT_W-1:0]             out_occupancy,
  output logic [bbsf_pkg::CNT_W-1:0]             out_free_space,
  output logic                                   out_ended,
  output logic                                   out_at_eof,
  output logic                                   out_error_flag,
  output logic [bbsf_pkg::TOT_W-1:0]             out_total_written,
  output logic [bbsf_pkg::TOT_W-1:0]             out_total_read
);

  localparam logic [bbsf_pkg::CNT_W-1:0] DEPTH_C   = bbsf_pkg::CNT_W'(bbsf_pkg::DEPTH);
  localparam logic [bbsf_pkg::LEN_W-1:0] MAX_LEN_C = bbsf_pkg::LEN_W'(bbsf_pkg::MAX_LEN);

  // Byte store.
  logic [bbsf_pkg::BYTE_W-1:0] mem [bbsf_pkg::DEPTH];

  // Captured request.
  logic [bbsf_pkg::OP_W-1:0]   op_r;
  logic [bbsf_pkg::BYTE_W-1:0] wb_r;
  logic [bbsf_pkg::LEN_W-1:0]  len_r;

  // FIFO state.
  logic [bbsf_pkg::ADDR_W-1:0] head_r, head_nxt;
  logic [bbsf_pkg::CNT_W-1:0]  fill_r, fill_nxt;
  logic                        end_r, end_nxt;
  logic                        err_r, err_nxt;
  logic [bbsf_pkg::TOT_W-1:0]  wcnt_r, wcnt_nxt;
  logic [bbsf_pkg::TOT_W-1:0]  rcnt_r, rcnt_nxt;
  logic [bbsf_pkg::CNT_W-1:0]  cap_r;

  // Streaming state.
  logic [bbsf_pkg::ADDR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [bbsf_pkg::LEN_W-1:0]  cnt_r, cnt_nxt;
  logic [bbsf_pkg::LEN_W-1:0]  moved_r, moved_nxt;
  logic                        rd_pend_r;
  logic                        rd_last_r;
  logic [bbsf_pkg::BYTE_W-1:0] rd_data_r;

  // Derived values.
  logic [bbsf_pkg::LEN_W-1:0]  len_sat;
  logic [bbsf_pkg::LEN_W-1:0]  n_avail;
  logic [bbsf_pkg::LEN_W-1:0]  n_read;
  logic [bbsf_pkg::CNT_W-1:0]  eff_cap;
  logic                        wr_ok;
  logic                        mem_we;
  logic [bbsf_pkg::ADDR_W-1:0] wr_addr;

  // Requested length limited to the maximum and to the bytes buffered.
  always_comb begin
    len_sat = (len_r > MAX_LEN_C) ? MAX_LEN_C : len_r;
    n_avail = (bbsf_pkg::CNT_W'(len_sat) < fill_r) ? len_sat
                                                   : fill_r[bbsf_pkg::LEN_W-1:0];
    n_read  = err_r ? '0 : n_avail;
    eff_cap = (cap_r > DEPTH_C) ? DEPTH_C : cap_r;
    wr_ok   = !end_r && !err_r && (fill_r < eff_cap);
    wr_addr = head_r + fill_r[bbsf_pkg::ADDR_W-1:0];
    mem_we  = cmd.exec && (op_r == bbsf_pkg::OP_WRITE) && wr_ok;
  end

  assign sts.stream     = (((op_r == bbsf_pkg::OP_READ) && !err_r) ||
                           (op_r == bbsf_pkg::OP_PEEK)) && (n_avail != '0);
  assign sts.issue_last = (cnt_r == bbsf_pkg::LEN_W'(1));

  // Execution of the captured request and stream bookkeeping.
  always_comb begin
    head_nxt   = head_r;
    fill_nxt   = fill_r;
    end_nxt    = end_r;
    err_nxt    = err_r;
    wcnt_nxt   = wcnt_r;
    rcnt_nxt   = rcnt_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    moved_nxt  = moved_r;
    if (cmd.exec) begin
      moved_nxt = '0;
      case (op_r)
        bbsf_pkg::OP_WRITE: begin
          if (wr_ok) begin
            fill_nxt  = fill_r + bbsf_pkg::CNT_W'(1);
            wcnt_nxt  = wcnt_r + bbsf_pkg::TOT_W'(1);
            moved_nxt = bbsf_pkg::LEN_W'(1);
          end
        end
        bbsf_pkg::OP_READ: begin
          rd_ptr_nxt = head_r;
          cnt_nxt    = n_read;
          head_nxt   = head_r + bbsf_pkg::ADDR_W'(n_read);
          fill_nxt   = fill_r - bbsf_pkg::CNT_W'(n_read);
          rcnt_nxt   = rcnt_r + bbsf_pkg::TOT_W'(n_read);
          moved_nxt  = n_read;
        end
        bbsf_pkg::OP_PEEK: begin
          rd_ptr_nxt = head_r;
          cnt_nxt    = n_avail;
        end
        bbsf_pkg::OP_POP: begin
          head_nxt  = head_r + bbsf_pkg::ADDR_W'(n_avail);
          fill_nxt  = fill_r - bbsf_pkg::CNT_W'(n_avail);
          rcnt_nxt  = rcnt_r + bbsf_pkg::TOT_W'(n_avail);
          moved_nxt = n_avail;
        end
        bbsf_pkg::OP_END: begin
          end_nxt = 1'b1;
        end
        bbsf_pkg::OP_ERROR: begin
          err_nxt = 1'b1;
        end
        default: begin
        end
      endcase
    end
    if (cmd.issue) begin
      rd_ptr_nxt = rd_ptr_r + bbsf_pkg::ADDR_W'(1);
      cnt_nxt    = cnt_r - bbsf_pkg::LEN_W'(1);
    end
  end

  // Control and status registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= '0;
      fill_r    <= '0;
      end_r     <= 1'b0;
      err_r     <= 1'b0;
      wcnt_r    <= '0;
      rcnt_r    <= '0;
      cap_r     <= bbsf_pkg::CAP_RESET;
      cnt_r     <= '0;
      rd_pend_r <= 1'b0;
      rd_last_r <= 1'b0;
    end else begin
      head_r    <= head_nxt;
      fill_r    <= fill_nxt;
      end_r     <= end_nxt;
      err_r     <= err_nxt;
      wcnt_r    <= wcnt_nxt;
      rcnt_r    <= rcnt_nxt;
      cnt_r     <= cnt_nxt;
      rd_pend_r <= cmd.issue;
      rd_last_r <= cmd.issue && sts.issue_last;
      if (cfg_write) begin
        cap_r <= cfg_capacity;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    rd_ptr_r <= rd_ptr_nxt;
    moved_r  <= moved_nxt;
    if (cmd.load) begin
      op_r  <= in_op;
      wb_r  <= in_write_byte;
      len_r <= in_length;
    end
  end

  // Byte store with one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wb_r;
    end
    if (cmd.issue) begin
      rd_data_r <= mem[rd_ptr_r];
    end
  end

  // Result ports; status fields always reflect the state after the request.
  always_comb begin
    out_strobe        = cmd.emit_status || rd_pend_r;
    out_byte_valid    = rd_pend_r;
    out_byte          = rd_pend_r ? rd_data_r : '0;
    out_last          = cmd.emit_status || (rd_pend_r && rd_last_r);
    out_moved         = moved_r;
    out_occupancy     = fill_r;
    out_free_space    = (eff_cap > fill_r) ? (eff_cap - fill_r) : '0;
    out_ended         = end_r;
    out_at_eof        = end_r && (fill_r == '0);
    out_error_flag    = err_r;
    out_total_written = wcnt_r;
    out_total_read    = rcnt_r;
  end

  // Occupancy never exceeds the store depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= DEPTH_C)
    else $error("occupancy above store depth");

  // An accepted write adds exactly one byte to the occupancy.
  a_write_fill: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |=> (fill_r == $past(fill_r) + bbsf_pkg::CNT_W'(1)))
    else $error("write did not grow occupancy by one");

  // The final store read produces the last result in the next cycle.
  a_last_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.issue && sts.issue_last) |=> (out_strobe && out_last && out_byte_valid))
    else $error("final streamed byte not marked last");

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for the bounded byte stream FIFO.
// Drives requests, predicts every result from its own model of the store, and checks them.
// Depends on bbsf_pkg and bounded_byte_stream_fifo.

module tb_top;

  // Opcodes that the block leaves undefined; they must change nothing.
  localparam logic [bbsf_pkg::OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [bbsf_pkg::OP_W-1:0] OP_SPARE_HI = 3'd7;

  localparam int CYCLE_LIMIT   = 250000;
  localparam int SETTLE_CYCLES = 8;
  localparam int REPORT_LIMIT  = 10;
  // Room for the most results one request can leave outstanding, with margin.
  localparam int RESULT_SLOTS  = 128;

  typedef struct {
    logic [bbsf_pkg::BYTE_W-1:0] data;
    logic                        data_ok;
    logic                        fin;
    logic [bbsf_pkg::LEN_W-1:0]  moved;
    logic [bbsf_pkg::CNT_W-1:0]  occupancy;
    logic [bbsf_pkg::CNT_W-1:0]  free_space;
    logic                        ended;
    logic                        at_eof;
    logic                        error_flag;
    logic [bbsf_pkg::TOT_W-1:0]  total_written;
    logic [bbsf_pkg::TOT_W-1:0]  total_read;
  } fifo_result_t;

  logic                        clk           = 1'b0;
  logic                        rst_n         = 1'b0;
  logic                        start         = 1'b0;
  logic                        busy;
  logic [bbsf_pkg::OP_W-1:0]   in_op         = '0;
  logic [bbsf_pkg::BYTE_W-1:0] in_write_byte = '0;
  logic [bbsf_pkg::LEN_W-1:0]  in_length     = '0;
  logic                        cfg_valid     = 1'b0;
  logic                        cfg_ready;
  logic [bbsf_pkg::CNT_W-1:0]  cfg_capacity  = '0;
  logic                        out_strobe;
  logic [bbsf_pkg::BYTE_W-1:0] out_byte;
  logic                        out_byte_valid;
  logic                        out_last;
  logic [bbsf_pkg::LEN_W-1:0]  out_moved;
  logic [bbsf_pkg::CNT_W-1:0]  out_occupancy;
  logic [bbsf_pkg::CNT_W-1:0]  out_free_space;
  logic                        out_ended;
  logic                        out_at_eof;
  logic                        out_error_flag;
  logic [bbsf_pkg::TOT_W-1:0]  out_total_written;
  logic [bbsf_pkg::TOT_W-1:0]  out_total_read;

  // Model of the FIFO state, updated when a request is accepted.
  logic [bbsf_pkg::BYTE_W-1:0] mdl_store [bbsf_pkg::DEPTH];
  int unsigned                 mdl_head     = 0;
  int unsigned                 mdl_fill     = 0;
  int unsigned                 mdl_capacity = bbsf_pkg::DEPTH;
  logic                        mdl_ended    = 1'b0;
  logic                        mdl_error    = 1'b0;
  logic [bbsf_pkg::TOT_W-1:0]  mdl_written  = '0;
  logic [bbsf_pkg::TOT_W-1:0]  mdl_read     = '0;

  // Ring of predicted results, oldest at awaited_rd.
  fifo_result_t awaited_results [RESULT_SLOTS];
  int           awaited_rd      = 0;
  int           awaited_wr      = 0;
  int           awaited_count   = 0;
  int           fault_count     = 0;
  int           cycle_count     = 0;
  int           sender_idle_pct = 21;

  bounded_byte_stream_fifo u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_op             (in_op),
    .in_write_byte     (in_write_byte),
    .in_length         (in_length),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_capacity      (cfg_capacity),
    .out_strobe        (out_strobe),
    .out_byte          (out_byte),
    .out_byte_valid    (out_byte_valid),
    .out_last          (out_last),
    .out_moved         (out_moved),
    .out_occupancy     (out_occupancy),
    .out_free_space    (out_free_space),
    .out_ended         (out_ended),
    .out_at_eof        (out_at_eof),
    .out_error_flag    (out_error_flag),
    .out_total_written (out_total_written),
    .out_total_read    (out_total_read)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  function automatic void log_fault(string what);
    fault_count++;
    if (fault_count <= REPORT_LIMIT) $display("%0t: %s", $time, what);
  endfunction

  // A capacity above the store depth behaves as the depth.
  function automatic int unsigned effective_capacity();
    return (mdl_capacity > bbsf_pkg::DEPTH) ? bbsf_pkg::DEPTH : mdl_capacity;
  endfunction

  // Queue one result carrying the status as it stands after the request.
  function automatic void queue_result(logic [bbsf_pkg::BYTE_W-1:0] b, logic ok, logic fin,
                                       int unsigned moved);
    fifo_result_t r;
    int unsigned  cap;
    cap             = effective_capacity();
    r.data          = b;
    r.data_ok       = ok;
    r.fin           = fin;
    r.moved         = bbsf_pkg::LEN_W'(moved);
    r.occupancy     = bbsf_pkg::CNT_W'(mdl_fill);
    r.free_space    = (cap > mdl_fill) ? bbsf_pkg::CNT_W'(cap - mdl_fill) : '0;
    r.ended         = mdl_ended;
    r.at_eof        = mdl_ended && (mdl_fill == 0);
    r.error_flag    = mdl_error;
    r.total_written = mdl_written;
    r.total_read    = mdl_read;
    if (awaited_count >= RESULT_SLOTS) begin
      log_fault("prediction ring overflow");
    end else begin
      awaited_results[awaited_wr] = r;
      awaited_wr = (awaited_wr + 1) % RESULT_SLOTS;
      awaited_count++;
    end
  endfunction

  // Apply one accepted request to the model and queue the results it causes.
  function automatic void predict_fifo_step(logic [bbsf_pkg::OP_W-1:0] op,
                                            logic [bbsf_pkg::BYTE_W-1:0] wbyte,
                                            logic [bbsf_pkg::LEN_W-1:0] req_len);
    int unsigned                 len;
    int unsigned                 n;
    int unsigned                 k;
    logic [bbsf_pkg::BYTE_W-1:0] taken [bbsf_pkg::MAX_LEN];
    len = (req_len > bbsf_pkg::MAX_LEN) ? bbsf_pkg::MAX_LEN : req_len;
    n   = (len < mdl_fill) ? len : mdl_fill;
    case (op)
      bbsf_pkg::OP_WRITE: begin
        if (!mdl_ended && !mdl_error && mdl_fill < effective_capacity()) begin
          mdl_store[(mdl_head + mdl_fill) % bbsf_pkg::DEPTH] = wbyte;
          mdl_fill++;
          mdl_written++;
          queue_result('0, 1'b0, 1'b1, 1);
        end else begin
          queue_result('0, 1'b0, 1'b1, 0);
        end
      end
      bbsf_pkg::OP_READ, bbsf_pkg::OP_PEEK: begin
        // A read in error returns nothing and pops nothing; a peek ignores the error.
        if (op == bbsf_pkg::OP_READ && mdl_error) n = 0;
        for (k = 0; k < n; k++) taken[k] = mdl_store[(mdl_head + k) % bbsf_pkg::DEPTH];
        if (op == bbsf_pkg::OP_READ) begin
          mdl_head = (mdl_head + n) % bbsf_pkg::DEPTH;
          mdl_fill -= n;
          mdl_read += n;
        end
        if (n == 0) begin
          queue_result('0, 1'b0, 1'b1, 0);
        end else begin
          for (k = 0; k < n; k++)
            queue_result(taken[k], 1'b1, k + 1 == n, (op == bbsf_pkg::OP_READ) ? n : 0);
        end
      end
      bbsf_pkg::OP_POP: begin
        mdl_head = (mdl_head + n) % bbsf_pkg::DEPTH;
        mdl_fill -= n;
        mdl_read += n;
        queue_result('0, 1'b0, 1'b1, n);
      end
      bbsf_pkg::OP_END: begin
        mdl_ended = 1'b1;
        queue_result('0, 1'b0, 1'b1, 0);
      end
      bbsf_pkg::OP_ERROR: begin
        mdl_error = 1'b1;
        queue_result('0, 1'b0, 1'b1, 0);
      end
      default: begin
        queue_result('0, 1'b0, 1'b1, 0);
      end
    endcase
  endfunction

  function automatic string describe(fifo_result_t r);
    return $sformatf({"byte=%02h bv=%b last=%b moved=%0d occ=%0d free=%0d ",
                      "end=%b eof=%b err=%b wr=%0d rd=%0d"},
                     r.data, r.data_ok, r.fin, r.moved, r.occupancy, r.free_space,
                     r.ended, r.at_eof, r.error_flag, r.total_written, r.total_read);
  endfunction

  // Compare every strobed result with the oldest outstanding prediction.
  always @(posedge clk) begin : check_results
    fifo_result_t seen;
    fifo_result_t want;
    logic         diff;
    if (rst_n === 1'b1 && out_strobe === 1'b1) begin
      seen.data          = out_byte;
      seen.data_ok       = out_byte_valid;
      seen.fin           = out_last;
      seen.moved         = out_moved;
      seen.occupancy     = out_occupancy;
      seen.free_space    = out_free_space;
      seen.ended         = out_ended;
      seen.at_eof        = out_at_eof;
      seen.error_flag    = out_error_flag;
      seen.total_written = out_total_written;
      seen.total_read    = out_total_read;
      if (awaited_count == 0) begin
        log_fault({"unexpected result: ", describe(seen)});
      end else begin
        want       = awaited_results[awaited_rd];
        awaited_rd = (awaited_rd + 1) % RESULT_SLOTS;
        awaited_count--;
        diff = (want.data !== seen.data) || (want.data_ok !== seen.data_ok) ||
               (want.fin !== seen.fin) || (want.moved !== seen.moved) ||
               (want.occupancy !== seen.occupancy) ||
               (want.free_space !== seen.free_space) ||
               (want.ended !== seen.ended) || (want.at_eof !== seen.at_eof) ||
               (want.error_flag !== seen.error_flag) ||
               (want.total_written !== seen.total_written) ||
               (want.total_read !== seen.total_read);
        if (diff)
          log_fault({"mismatch\n  expected ", describe(want), "\n  actual   ", describe(seen)});
      end
    end
  end

  // Present one request, optionally after a random gap, and wait until it is taken.
  task automatic send_request(input logic [bbsf_pkg::OP_W-1:0] op,
                              input logic [bbsf_pkg::BYTE_W-1:0] wbyte,
                              input logic [bbsf_pkg::LEN_W-1:0] req_len);
    int unsigned gap;
    if ($urandom_range(99) < sender_idle_pct) begin
      gap = $urandom_range(1, 6);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_op         <= op;
    in_write_byte <= wbyte;
    in_length     <= req_len;
    start         <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    predict_fifo_step(op, wbyte, req_len);
  endtask

  // Hold off new requests until every predicted result has arrived and the block is idle.
  task automatic wait_for_drain();
    start <= 1'b0;
    while (awaited_count != 0 || busy !== 1'b0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [bbsf_pkg::CNT_W-1:0] value);
    wait_for_drain();
    cfg_valid    <= 1'b1;
    cfg_capacity <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid    <= 1'b0;
    mdl_capacity = value;
  endtask

  // Write, read, peek, pop and the spare opcodes on an empty and a short buffer, byte and length extremes.
  task automatic test_basic_ops();
    send_request(bbsf_pkg::OP_READ, 8'h00, 7'd5);
    send_request(bbsf_pkg::OP_WRITE, 8'h00, 7'd0);
    send_request(bbsf_pkg::OP_WRITE, 8'hFF, 7'd127);
    send_request(bbsf_pkg::OP_WRITE, 8'hA5, 7'd0);
    send_request(bbsf_pkg::OP_PEEK, 8'h00, 7'd0);
    send_request(bbsf_pkg::OP_PEEK, 8'h00, 7'd127);
    send_request(bbsf_pkg::OP_READ, 8'h00, 7'd1);
    send_request(OP_SPARE_LO, 8'h5A, 7'd3);
    send_request(OP_SPARE_HI, 8'hC3, 7'd64);
    send_request(bbsf_pkg::OP_POP, 8'h00, 7'd1);
    send_request(bbsf_pkg::OP_READ, 8'h00, 7'd127);
    send_request(bbsf_pkg::OP_POP, 8'h00, 7'd3);
  endtask

  // Zero capacity, capacity beyond the depth, a full buffer, capacity below occupancy.
  task automatic test_capacity_limits();
    write_capacity(11'd0);
    send_request(bbsf_pkg::OP_WRITE, 8'h3C, 7'd0);
    write_capacity(11'd2047);
    send_request(bbsf_pkg::OP_WRITE, 8'h11, 7'd0);
    send_request(bbsf_pkg::OP_WRITE, 8'h22, 7'd0);
    write_capacity(11'd3);
    send_request(bbsf_pkg::OP_WRITE, 8'h33, 7'd0);
    send_request(bbsf_pkg::OP_WRITE, 8'h44, 7'd0);
    write_capacity(11'd1);
    send_request(bbsf_pkg::OP_WRITE, 8'h55, 7'd0);
    send_request(bbsf_pkg::OP_READ, 8'h00, 7'd1);
    send_request(bbsf_pkg::OP_POP, 8'h00, 7'd64);
    write_capacity(bbsf_pkg::CAP_RESET);
  endtask

  // Random requests in alternating fill and drain stretches; unused opcodes are not counted.
  task automatic test_random_traffic(input int items, input int idle_pct,
                                     input logic [bbsf_pkg::CNT_W-1:0] cap, input bit all_ops);
    int                         sent;
    bit                         filling;
    int unsigned                pick;
    logic [bbsf_pkg::OP_W-1:0]  op;
    logic [bbsf_pkg::LEN_W-1:0] req_len;
    write_capacity(cap);
    sender_idle_pct = idle_pct;
    sent    = 0;
    filling = 1'b1;
    while (sent < items) begin
      if ($urandom_range(14) == 0) filling = !filling;
      pick = $urandom_range(99);
      if (all_ops) begin
        op = bbsf_pkg::OP_W'($urandom_range(7));
      end else if (pick >= 96) begin
        op = $urandom_range(1) ? OP_SPARE_HI : OP_SPARE_LO;
      end else if (filling) begin
        op = (pick < 80) ? bbsf_pkg::OP_WRITE : (pick < 86) ? bbsf_pkg::OP_READ :
             (pick < 91) ? bbsf_pkg::OP_PEEK : bbsf_pkg::OP_POP;
      end else begin
        op = (pick < 20) ? bbsf_pkg::OP_WRITE : (pick < 50) ? bbsf_pkg::OP_READ :
             (pick < 70) ? bbsf_pkg::OP_PEEK : bbsf_pkg::OP_POP;
      end
      pick = $urandom_range(99);
      if (pick < 75)      req_len = bbsf_pkg::LEN_W'($urandom_range(0, 16));
      else if (pick < 93) req_len = bbsf_pkg::LEN_W'($urandom_range(17, 64));
      else                req_len = bbsf_pkg::LEN_W'($urandom_range(65, 127));
      send_request(op, bbsf_pkg::BYTE_W'($urandom), req_len);
      if (op != OP_SPARE_LO && op != OP_SPARE_HI) sent++;
      if ($urandom_range(49) == 0) wait_for_drain();
    end
  endtask

  // End of input with data buffered, then the error flag: reads stop, peek and pop go on.
  task automatic test_end_and_error();
    int k;
    sender_idle_pct = 21;
    send_request(bbsf_pkg::OP_POP, 8'h00, 7'd127);
    send_request(bbsf_pkg::OP_POP, 8'h00, 7'd127);
    for (k = 0; k < 5; k++) send_request(bbsf_pkg::OP_WRITE, bbsf_pkg::BYTE_W'($urandom), 7'd0);
    send_request(bbsf_pkg::OP_END, 8'h00, 7'd0);
    send_request(bbsf_pkg::OP_WRITE, 8'h77, 7'd0);
    send_request(bbsf_pkg::OP_READ, 8'h00, 7'd2);
    send_request(bbsf_pkg::OP_ERROR, 8'h00, 7'd0);
    send_request(bbsf_pkg::OP_READ, 8'h00, 7'd3);
    send_request(bbsf_pkg::OP_PEEK, 8'h00, 7'd127);
    send_request(bbsf_pkg::OP_POP, 8'h00, 7'd1);
    send_request(bbsf_pkg::OP_POP, 8'h00, 7'd64);
    send_request(bbsf_pkg::OP_READ, 8'h00, 7'd4);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_basic_ops();
    test_capacity_limits();
    test_random_traffic(70, 21, 11'd48, 1'b0);
    test_random_traffic(70, 61, 11'd2047, 1'b0);
    test_random_traffic(70, 0, 11'd20, 1'b0);
    test_end_and_error();
    test_random_traffic(30, 21, bbsf_pkg::CAP_RESET, 1'b1);
    wait_for_drain();
    if (fault_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

FILE: bounded_byte_stream_fifo.f
hw/rtl/bbsf_pkg.sv
hw/rtl/bbsf_ctrl.sv
hw/rtl/bbsf_dp.sv
hw/rtl/bounded_byte_stream_fifo.sv
tb/tb_top.sv
